// ----- src/dsbf_pkg.sv -----
// shared types and field widths for the dyadic to stern-brocot block
package dsbf_pkg;

  localparam int POS_W   = 61;
  localparam int LEVEL_W = 6;
  localparam int FRAC_W  = 49;
  localparam int EXT_W   = 64;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [FRAC_W-1:0]  frac_t;
  typedef logic [EXT_W-1:0]   ext_t;

  // bounds of the walk travelling down the chain
  typedef struct packed {
    logic  vld;
    logic  err;
    frac_t lp;
    frac_t lq;
    frac_t rp;
    frac_t rq;
  } walk_t;

endpackage

// ----- src/dsbf_front.sv -----
// input decode stage: special cases, start bounds and per-bit step masks
module dsbf_front #(
  parameter int MAX_LEVEL = 60
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  dsbf_pkg::pos_t        pos,
  input  dsbf_pkg::level_t      level,
  output dsbf_pkg::walk_t       walk,
  output logic [MAX_LEVEL-1:0]  dir,
  output logic [MAX_LEVEL-1:0]  act
);
  import dsbf_pkg::*;

  ext_t                 xe;
  ext_t                 denom;
  logic                 err;
  logic                 is_zero;
  logic                 is_one;
  logic                 normal;
  walk_t                walk_next;
  logic [MAX_LEVEL-1:0] dir_next;
  logic [MAX_LEVEL-1:0] act_next;

  always_comb begin
    xe      = EXT_W'(pos);
    denom   = ext_t'(1) << level;
    err     = (level > LEVEL_W'(MAX_LEVEL)) || (xe > denom);
    is_zero = (pos == '0);
    is_one  = (xe == denom);
    normal  = !err && !is_zero && !is_one;

    walk_next.vld = in_vld;
    walk_next.err = err;
    // special results are set up so that the final mediant yields them
    if (normal) begin
      walk_next.lp = '0;
      walk_next.lq = FRAC_W'(1);
      walk_next.rp = FRAC_W'(1);
      walk_next.rq = FRAC_W'(1);
    end else begin
      walk_next.lp = '0;
      walk_next.lq = '0;
      walk_next.rp = (is_one && !err) ? FRAC_W'(1) : '0;
      walk_next.rq = FRAC_W'(1);
    end

    // a bit steps only below the level and above the lowest set bit
    for (int k = 0; k < MAX_LEVEL; k++) begin
      dir_next[k] = xe[k];
      if (k == 0) begin
        act_next[k] = 1'b0;
      end else begin
        act_next[k] = normal && (LEVEL_W'(k) < level) &&
                      ((xe & ((ext_t'(1) << k) - ext_t'(1))) != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk.vld <= 1'b0;
    end else if (en) begin
      walk.vld <= walk_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      walk.err <= walk_next.err;
      walk.lp  <= walk_next.lp;
      walk.lq  <= walk_next.lq;
      walk.rp  <= walk_next.rp;
      walk.rq  <= walk_next.rq;
      dir      <= dir_next;
      act      <= act_next;
    end
  end

endmodule

// ----- src/dsbf_cell.sv -----
// one cell of the chain: a single mediant step for its bit position
module dsbf_cell #(
  parameter int MAX_LEVEL = 60,
  parameter int BIT       = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  dsbf_pkg::walk_t       walk_in,
  input  logic [MAX_LEVEL-1:0]  dir_in,
  input  logic [MAX_LEVEL-1:0]  act_in,
  output dsbf_pkg::walk_t       walk_out,
  output logic [MAX_LEVEL-1:0]  dir_out,
  output logic [MAX_LEVEL-1:0]  act_out
);
  import dsbf_pkg::*;

  frac_t mp;
  frac_t mq;
  walk_t walk_next;

  always_comb begin
    mp        = walk_in.lp + walk_in.rp;
    mq        = walk_in.lq + walk_in.rq;
    walk_next = walk_in;
    if (act_in[BIT]) begin
      if (dir_in[BIT]) begin
        walk_next.lp = mp;
        walk_next.lq = mq;
      end else begin
        walk_next.rp = mp;
        walk_next.rq = mq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_out.vld <= 1'b0;
    end else if (en) begin
      walk_out.vld <= walk_next.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      walk_out.err <= walk_next.err;
      walk_out.lp  <= walk_next.lp;
      walk_out.lq  <= walk_next.lq;
      walk_out.rp  <= walk_next.rp;
      walk_out.rq  <= walk_next.rq;
      dir_out      <= dir_in;
      act_out      <= act_in;
    end
  end

endmodule

// ----- src/dyadic_to_stern_brocot_fraction.sv -----
// top level: dyadic pos/2^level to stern-brocot fraction p/q
//
// input channel: in_valid/in_stall carry pos and level; a beat is taken at a
// rising edge with in_valid high and in_stall low.
// output channel: out_valid/out_stall carry p, q and range_error, one beat
// per input beat, in order.
// the work runs down a chain of MAX_LEVEL-1 cells, one per bit position of
// pos from the top down, each doing one mediant add on the travelling bounds.
// a decode stage sits in front of the chain and an output register after it.
// throughput: one beat per cycle when not stalled; all stages move together.
// out_stall with a valid result freezes the whole chain and raises in_stall
// in the same cycle; held results and their payload stay put.
// pos above 2^level, or level above MAX_LEVEL, gives 0/1 with range_error.
// synchronous reset empties every stage; no result is pending afterward.
module dyadic_to_stern_brocot_fraction #(
  parameter int MAX_LEVEL = 60
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  dsbf_pkg::pos_t   pos,
  input  dsbf_pkg::level_t level,
  output logic             out_valid,
  input  logic             out_stall,
  output dsbf_pkg::frac_t  p,
  output dsbf_pkg::frac_t  q,
  output logic             range_error
);
  import dsbf_pkg::*;

  localparam int NCELL = MAX_LEVEL - 1;

  logic                 en;
  walk_t                walk [0:NCELL];
  logic [MAX_LEVEL-1:0] dir  [0:NCELL];
  logic [MAX_LEVEL-1:0] act  [0:NCELL];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  dsbf_front #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_vld (in_valid),
    .pos    (pos),
    .level  (level),
    .walk   (walk[0]),
    .dir    (dir[0]),
    .act    (act[0])
  );

  // cell j handles bit position MAX_LEVEL-1-j
  for (genvar j = 0; j < NCELL; j++) begin : g_cell
    dsbf_cell #(
      .MAX_LEVEL (MAX_LEVEL),
      .BIT       (MAX_LEVEL - 1 - j)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .walk_in  (walk[j]),
      .dir_in   (dir[j]),
      .act_in   (act[j]),
      .walk_out (walk[j+1]),
      .dir_out  (dir[j+1]),
      .act_out  (act[j+1])
    );
  end

  // final mediant of the two bounds
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= walk[NCELL].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p           <= walk[NCELL].lp + walk[NCELL].rp;
      q           <= walk[NCELL].lq + walk[NCELL].rq;
      range_error <= walk[NCELL].err;
    end
  end

endmodule

// ----- src/dsbf_checker.sv -----
// port-level checker for the dyadic to stern-brocot block, with its bind
module dsbf_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input dsbf_pkg::frac_t  p,
  input dsbf_pkg::frac_t  q,
  input logic             range_error
);
  import dsbf_pkg::*;

  // a held result beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(p) && $stable(q) &&
                               $stable(range_error))
    else $error("held output beat changed");

  // the input side only stalls behind a held result beat
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held output beat");

  // a rejected input always reads as 0/1
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> p == '0 && q == FRAC_W'(1))
    else $error("range error without 0/1");

  // results lie in [0, 1] with a nonzero denominator
  a_unit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> q != '0 && p <= q)
    else $error("fraction outside unit interval");

  // reset leaves no pending result
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind dyadic_to_stern_brocot_fraction dsbf_checker u_dsbf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .p           (p),
  .q           (q),
  .range_error (range_error)
);

// ----- tb/dyadic_to_stern_brocot_fraction_test.sv -----
// self-checking testbench for the dyadic to stern-brocot fraction block
`timescale 1ns / 1ps

module dyadic_to_stern_brocot_fraction_test;
  import dsbf_pkg::*;

  localparam int MAX_LEVEL   = 60;
  localparam int DRAIN_WAIT  = MAX_LEVEL + 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PTS  = 500;

  typedef struct {
    frac_t p;
    frac_t q;
    logic  err;
  } frac_result_t;

  // expected fractions in arrival order, with the walk that produces them
  class fraction_scoreboard;
    frac_result_t pending[$];
    int points;
    int checked;
    int rejected;
    int mismatches;

    function void stern_brocot_of(input pos_t x_in, input level_t lv_in,
                                  output frac_result_t r);
      logic [63:0] x, denom, lp, lq, rp, rq, mp, mq;
      int unsigned lv;
      x = 64'(x_in);
      lv = lv_in;
      r.p = '0;
      r.q = frac_t'(1);
      r.err = 1'b0;
      if (lv > MAX_LEVEL) begin
        r.err = 1'b1;
        return;
      end
      denom = 64'd1 << lv;
      if (x > denom) begin
        r.err = 1'b1;
      end else if (x == denom) begin
        r.p = frac_t'(1);
      end else if (x != 0) begin
        while (x[0] == 1'b0 && lv > 0) begin
          x = x >> 1;
          lv--;
        end
        lp = 0; lq = 1; rp = 1; rq = 1;
        for (int i = lv; i > 1; i--) begin
          mp = lp + rp;
          mq = lq + rq;
          if (x[i-1]) begin
            lp = mp; lq = mq;
          end else begin
            rp = mp; rq = mq;
          end
        end
        r.p = frac_t'(lp + rp);
        r.q = frac_t'(lq + rq);
      end
    endfunction

    function void note_point(pos_t x, level_t lv);
      frac_result_t r;
      stern_brocot_of(x, lv, r);
      pending.push_back(r);
      points++;
      if (r.err) rejected++;
    endfunction

    function void check_fraction(frac_t p_got, frac_t q_got, logic err_got);
      frac_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: p=%0d q=%0d range_error=%0b",
                   p_got, q_got, err_got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.p !== p_got || want.q !== q_got || want.err !== err_got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: expected p=%0d q=%0d range_error=%0b, got p=%0d q=%0d range_error=%0b",
                   checked, want.p, want.q, want.err, p_got, q_got, err_got);
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  pos_t   pos = '0;
  level_t level = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  frac_t  p;
  frac_t  q;
  logic   range_error;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  fraction_scoreboard sb = new();

  dyadic_to_stern_brocot_fraction #(.MAX_LEVEL(MAX_LEVEL)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pos(pos),
    .level(level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .p(p),
    .q(q),
    .range_error(range_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_point(pos, level);
      if (out_valid && !out_stall) sb.check_fraction(p, q, range_error);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.pending.size());
      $display("dyadic_to_stern_brocot_fraction_test NOT OK");
      $finish;
    end
  end

  // one input beat; returns at the edge that takes it
  task automatic send_point(input pos_t x, input level_t lv);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pos = x;
    level = lv;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_point();
    int unsigned pick;
    int unsigned lv;
    int unsigned k;
    logic [63:0] r64;
    logic [63:0] denom;
    logic [63:0] x;
    pick = $urandom_range(0, 99);
    r64 = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) lv = $urandom_range(50, MAX_LEVEL);
    else lv = $urandom_range(1, MAX_LEVEL);
    denom = 64'd1 << lv;
    if (pick < 45) begin
      x = r64 & (denom - 1);
    end else if (pick < 70) begin
      // force a run of trailing zeros so the stripping gets exercised
      k = $urandom_range(0, lv - 1);
      x = ((r64 & ((64'd1 << (lv - k)) - 1)) | 64'd1) << k;
    end else if (pick < 78) begin
      lv = $urandom_range(0, MAX_LEVEL);
      x = $urandom_range(0, 1) ? (64'd1 << lv) : 64'd0;
    end else if (pick < 90) begin
      lv = $urandom_range(0, MAX_LEVEL);
      x = (64'd1 << lv) + 1 + $urandom_range(0, 1000);
    end else begin
      lv = $urandom_range(0, 63);
      x = r64;
    end
    send_point(pos_t'(x), level_t'(lv));
  endtask

  task automatic send_directed();
    send_point(pos_t'(0), level_t'(0));
    send_point(pos_t'(1), level_t'(0));
    send_point(pos_t'(2), level_t'(0));
    send_point(pos_t'(0), level_t'(60));
    send_point(pos_t'(64'd1 << 60), level_t'(60));
    send_point(pos_t'((64'd1 << 60) + 1), level_t'(60));
    send_point('1, level_t'(60));
    send_point(pos_t'(1), level_t'(60));
    send_point(pos_t'((64'd1 << 60) - 1), level_t'(60));
    send_point(pos_t'(64'h0555_5555_5555_5555), level_t'(60));
    send_point(pos_t'(64'h0aaa_aaaa_aaaa_aaaa), level_t'(60));
    send_point(pos_t'(64'd1 << 59), level_t'(60));
    send_point(pos_t'(1), level_t'(61));
    send_point(pos_t'(0), level_t'(61));
    send_point(pos_t'(0), level_t'(63));
    send_point('1, level_t'(63));
    send_point(pos_t'(1), level_t'(1));
    send_point(pos_t'(1), level_t'(2));
    send_point(pos_t'(3), level_t'(2));
    send_point(pos_t'(5), level_t'(3));
    send_point(pos_t'(64'd1 << 30), level_t'(30));
    send_point(pos_t'((64'd1 << 30) + 1), level_t'(30));
    send_point(pos_t'(1), level_t'(59));
    send_point(pos_t'(64'h0fff_ffff_ffff_fffe), level_t'(60));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 12;
    recv_stall_pct = 62;
    send_directed();
    // hold the sender off until the pipe is empty
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();

    for (int i = 0; i < RANDOM_PTS; i++) begin
      if (i == RANDOM_PTS / 3) begin
        send_idle_pct = 62;
        recv_stall_pct = 12;
      end else if (i == 2 * RANDOM_PTS / 3) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      send_random_point();
    end
    @(negedge clk);
    in_valid = 1'b0;

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d points sent under three idle mixes, %0d fractions checked, %0d rejected",
             sb.points, sb.checked, sb.rejected);
    $display("%0d mismatches, %0d results still expected",
             sb.mismatches, sb.pending.size());
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("dyadic_to_stern_brocot_fraction_test OK");
    end else begin
      $display("dyadic_to_stern_brocot_fraction_test NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/dsbf_pkg.sv
src/dsbf_front.sv
src/dsbf_cell.sv
src/dyadic_to_stern_brocot_fraction.sv
src/dsbf_checker.sv
tb/dyadic_to_stern_brocot_fraction_test.sv
